/* src/kscat_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// kscat_pkg
// Shared types and constants for the keyed sum/count/average table: beat
// formats of both channels, the internal command format, widths of the
// accumulators and of the divider, and the states of the table engine.
// ============================================================================
package kscat_pkg;

    // Default number of table entries (groups held between reports).
    localparam int TABLE_ENTRIES_DEF = 32;

    // Depth of the command queue between the front and the table engine.
    localparam int QUEUE_DEPTH = 2;

    // Field widths.
    localparam int KEY_W   = 8;
    localparam int VALUE_W = 8;
    localparam int SUM_W   = 32;
    localparam int COUNT_W = 24;
    localparam int QUO_W   = 12;

    // Divider operands: 20*sum + count needs 37 bits, 2*count needs 25 bits.
    localparam int NUM_W = 37;
    localparam int DEN_W = COUNT_W + 1;

    // Width of one sum/count memory word.
    localparam int ACC_W = SUM_W + COUNT_W;

    // Largest count a group can hold; further adds to it are dropped.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes of an input beat.
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Input beat.
    typedef struct packed {
        logic               operation;
        logic [KEY_W-1:0]   group_key;
        logic [VALUE_W-1:0] sample_value;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic               group_valid;
        logic [KEY_W-1:0]   out_key;
        logic [QUO_W-1:0]   average_tenths;
        logic               overflow_seen;
        logic               last_result;
    } out_item_t;

    // Classified command handed from the front to the table engine.
    typedef struct packed {
        logic               is_report;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // Table engine states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LOOK,
        ST_ACC,
        ST_RD,
        ST_PREP,
        ST_START,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

/* src/kscat_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// kscat_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module kscat_ram #(
    parameter int WIDTH = kscat_pkg::ACC_W,
    parameter int DEPTH = kscat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/kscat_div.sv */
`timescale 1ns / 1ps
// ============================================================================
// kscat_div
// Restoring divider producing a quotient known to be below 2^QUO_W, one
// quotient bit per cycle, most significant bit first.
// ============================================================================
module kscat_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [kscat_pkg::NUM_W-1:0]     num,
    input  logic [kscat_pkg::DEN_W-1:0]     den,
    output logic                            busy,
    output logic [kscat_pkg::QUO_W-1:0]     quotient
);

    localparam int NUM_W  = kscat_pkg::NUM_W;
    localparam int QUO_W  = kscat_pkg::QUO_W;
    localparam int STEP_W = $clog2(QUO_W);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [NUM_W:0]    diff;
    logic              fits;

    // Trial subtraction of the shifted divisor.
    assign diff = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign fits = ~diff[NUM_W];

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(QUO_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // Remainder, shifted divisor and quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= NUM_W'({den, {(QUO_W - 1){1'b0}}});
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[NUM_W-1:0];
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* src/kscat_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// kscat_front
// Input side: accepts beats, decodes the operation into a command and holds
// commands in a short queue until the table engine takes them.
// ============================================================================
module kscat_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  kscat_pkg::in_item_t item,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output kscat_pkg::cmd_t     cmd
);

    localparam int DEPTH = kscat_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kscat_pkg::cmd_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;
    kscat_pkg::cmd_t  decoded;

    assign item_ready = (count_reg != CNT_W'(DEPTH));
    assign cmd_valid  = (count_reg != '0);
    assign push       = item_valid & item_ready;
    assign pop        = cmd_valid & cmd_ready;
    assign cmd        = slot_reg[rd_ptr_reg];

    // Classify the incoming beat.
    always_comb
    begin
        decoded.is_report = (item.operation == kscat_pkg::OP_REPORT);
        decoded.key       = item.group_key;
        decoded.value     = item.sample_value;
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

/* src/kscat_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// kscat_back
// Table engine: key lookup and accumulation for add commands, and the report
// sweep that divides each group's sum by its count and drives result beats.
// ============================================================================
module kscat_back #(
    parameter int TABLE_ENTRIES = kscat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  kscat_pkg::cmd_t      cmd,
    output logic                 result_valid,
    input  logic                 result_ready,
    output kscat_pkg::out_item_t result
);

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W   = kscat_pkg::KEY_W;
    localparam int VALUE_W = kscat_pkg::VALUE_W;
    localparam int SUM_W   = kscat_pkg::SUM_W;
    localparam int COUNT_W = kscat_pkg::COUNT_W;
    localparam int ACC_W   = kscat_pkg::ACC_W;
    localparam int NUM_W   = kscat_pkg::NUM_W;
    localparam int QUO_W   = kscat_pkg::QUO_W;

    kscat_pkg::state_t state_reg;
    kscat_pkg::state_t state_next;

    // Control state.
    logic [CNT_W-1:0]   used_reg;
    logic               ovf_reg;
    logic [IDX_W-1:0]   rpt_idx_reg;
    logic               result_valid_reg;

    // Working registers.
    logic [KEY_W-1:0]   key_reg [TABLE_ENTRIES];
    logic [KEY_W-1:0]   cur_key_reg;
    logic [VALUE_W-1:0] cur_val_reg;
    logic               empty_reg;
    logic [TABLE_ENTRIES-1:0] match_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [NUM_W-1:0]   num20_reg;
    logic [COUNT_W-1:0] cnt_reg;
    kscat_pkg::out_item_t result_reg;

    // Combinational helpers.
    logic [TABLE_ENTRIES-1:0] match_next;
    logic [IDX_W-1:0]   hit_idx;
    logic               hit;
    logic               full;
    logic               last;
    logic               saturated;
    logic [SUM_W-1:0]   rd_sum;
    logic [COUNT_W-1:0] rd_cnt;
    logic [IDX_W-1:0]   used_idx;

    // Memory and divider hookup.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ACC_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ACC_W-1:0]   ram_rdata;
    logic               div_start;
    logic               div_busy;
    logic [QUO_W-1:0]   div_quotient;
    logic               out_load;

    kscat_ram #(
        .WIDTH (ACC_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kscat_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num20_reg + NUM_W'(cnt_reg)),
        .den      ({cnt_reg, 1'b0}),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign rd_sum    = ram_rdata[ACC_W-1:COUNT_W];
    assign rd_cnt    = ram_rdata[COUNT_W-1:0];
    assign saturated = (rd_cnt == kscat_pkg::COUNT_MAX);
    assign used_idx  = used_reg[IDX_W-1:0];
    assign full      = (used_reg == CNT_W'(TABLE_ENTRIES));
    assign hit       = |match_reg;
    assign last      = empty_reg | ((CNT_W'(rpt_idx_reg) + CNT_W'(1)) == used_reg);

    // Compare the current key against every occupied entry.
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_next[i] = (key_reg[i] == cur_key_reg) && (CNT_W'(i) < used_reg);
        end
    end

    // Keys are unique, so at most one match bit is set: OR the indexes.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kscat_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (!cmd.is_report)
                    begin
                        state_next = kscat_pkg::ST_MATCH;
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = kscat_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = kscat_pkg::ST_RD;
                    end
                end
            end
            kscat_pkg::ST_MATCH: state_next = kscat_pkg::ST_LOOK;
            kscat_pkg::ST_LOOK:  state_next = hit ? kscat_pkg::ST_ACC : kscat_pkg::ST_IDLE;
            kscat_pkg::ST_ACC:   state_next = kscat_pkg::ST_IDLE;
            kscat_pkg::ST_RD:    state_next = kscat_pkg::ST_PREP;
            kscat_pkg::ST_PREP:  state_next = kscat_pkg::ST_START;
            kscat_pkg::ST_START: state_next = kscat_pkg::ST_DIV;
            kscat_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = kscat_pkg::ST_EMIT;
                end
            end
            kscat_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = last ? kscat_pkg::ST_IDLE : kscat_pkg::ST_RD;
                end
            end
            default: state_next = kscat_pkg::ST_IDLE;
        endcase
    end

    // State outputs: queue pop, memory access, divider start, result load.
    always_comb
    begin
        cmd_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            kscat_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            kscat_pkg::ST_LOOK:
            begin
                if (hit)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = hit_idx;
                end
                else if (!full)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = used_idx;
                    ram_wdata = {SUM_W'(cur_val_reg), COUNT_W'(1)};
                end
            end
            kscat_pkg::ST_ACC:
            begin
                if (!saturated)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = hit_idx_reg;
                    ram_wdata = {rd_sum + SUM_W'(cur_val_reg), rd_cnt + COUNT_W'(1)};
                end
            end
            kscat_pkg::ST_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = rpt_idx_reg;
            end
            kscat_pkg::ST_START:
            begin
                div_start = 1'b1;
            end
            kscat_pkg::ST_EMIT:
            begin
                out_load = ~result_valid_reg | result_ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kscat_pkg::ST_IDLE;
            used_reg         <= '0;
            ovf_reg          <= 1'b0;
            rpt_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Fill count and sticky overflow.
            if ((state_reg == kscat_pkg::ST_LOOK) && !hit)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    used_reg <= used_reg + CNT_W'(1);
                end
            end
            if ((state_reg == kscat_pkg::ST_ACC) && saturated)
            begin
                ovf_reg <= 1'b1;
            end

            // Report sweep index; the table empties after the last beat.
            if ((state_reg == kscat_pkg::ST_IDLE) && cmd_valid)
            begin
                rpt_idx_reg <= '0;
            end
            if (out_load)
            begin
                rpt_idx_reg <= rpt_idx_reg + IDX_W'(1);
                if (last)
                begin
                    used_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
            end

            // Result register.
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == kscat_pkg::ST_IDLE) && cmd_valid)
        begin
            cur_key_reg <= cmd.key;
            cur_val_reg <= cmd.value;
            empty_reg   <= (used_reg == '0);
        end
        if (state_reg == kscat_pkg::ST_MATCH)
        begin
            match_reg <= match_next;
        end
        if (state_reg == kscat_pkg::ST_LOOK)
        begin
            hit_idx_reg <= hit_idx;
            if (!hit && !full)
            begin
                key_reg[used_idx] <= cur_key_reg;
            end
        end
        if (state_reg == kscat_pkg::ST_PREP)
        begin
            // 20*sum as 16*sum + 4*sum.
            num20_reg <= (NUM_W'(rd_sum) << 4) + (NUM_W'(rd_sum) << 2);
            cnt_reg   <= rd_cnt;
        end
        if (out_load)
        begin
            result_reg.group_valid    <= ~empty_reg;
            result_reg.out_key        <= empty_reg ? '0 : key_reg[rpt_idx_reg];
            result_reg.average_tenths <= empty_reg ? '0 : div_quotient;
            result_reg.overflow_seen  <= ovf_reg;
            result_reg.last_result    <= last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* src/keyed_sum_count_average_table.sv */
`timescale 1ns / 1ps
// ============================================================================
// keyed_sum_count_average_table
// Group-by aggregation table: per-key sum and count, reported as averages.
// ============================================================================
// An add beat (operation 0) adds sample_value to the sum of group_key and
// bumps its count, or opens a new entry for an unseen key; when all
// TABLE_ENTRIES are taken, or a group's count is at its 24-bit maximum, the
// add is dropped and the sticky overflow flag is set. A report beat
// (operation 1) returns one result beat per group in the order the groups
// first appeared, with the average in tenths rounded half up, then empties
// the table and clears the flag; an empty table returns a single beat with
// group_valid low. Input beats land in a two-entry command queue, so the
// input side can take up to two beats ahead of the table engine, also while
// a result waits to be taken. The engine handles one command at a time: an
// add goes through key compare and encode, then a memory read and an
// accumulate for a known key or a memory write for a new one. A report
// reads each group, prepares the operands and runs the shift-subtract
// divider that forms each average, then drives the result beat, waiting
// while the consumer holds it off; an empty table goes straight to its beat.
// ============================================================================
module keyed_sum_count_average_table #(
    parameter int TABLE_ENTRIES = kscat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  kscat_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output kscat_pkg::out_item_t result
);

    logic            cmd_valid;
    logic            cmd_ready;
    kscat_pkg::cmd_t cmd;

    // Front: accept and classify input beats.
    kscat_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // Back: table engine and result register.
    kscat_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
